[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tmacd_pkg.sv]
// ----------------------------------------------------------------------------
// tmacd_pkg
// constants, widths and control types of the triaxial moving average block
// ----------------------------------------------------------------------------
package tmacd_pkg;

  localparam int WINDOW   = 10;
  localparam int NUM_AXES = 3;
  localparam int SAMPLE_W = 16;

  // log2 of the window, rounded up
  localparam int L       = $clog2(WINDOW);
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = SAMPLE_W + L;
  localparam int MAG_W   = SAMPLE_W + L;
  localparam int LIMIT_W = SAMPLE_W + L;
  localparam int CMP_W   = SAMPLE_W + 1 + L;

  // exact reciprocal for truncating division of a MAG_W magnitude by WINDOW
  localparam int SHIFT_K = MAG_W + L;
  localparam int RECIP_W = SAMPLE_W + 1 + L;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [SAMPLE_W-1:0] THR_RESET   = 16'd835;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(835 * WINDOW);
  localparam logic [SLOT_W-1:0]   SLOT_LAST   = SLOT_W'(WINDOW - 1);

  typedef struct packed {
    logic              load;     // input transaction taken this cycle
    logic              adv2;     // first stage moves into the multiply stage
    logic              adv3;     // multiply stage moves into the output register
    logic [SLOT_W-1:0] slot;     // window entry written by the current load
    logic [SLOT_W-1:0] slot_nxt; // entry that the next load replaces
  } tmacd_ctl_t;

endpackage

[rtl/tmacd_lane.sv]
// ----------------------------------------------------------------------------
// tmacd_lane
// one axis: sample window memory, running sum and change test
// ----------------------------------------------------------------------------
module tmacd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  tmacd_pkg::tmacd_ctl_t         ctl,
  input  logic signed [15:0]            sample,
  input  logic [tmacd_pkg::LIMIT_W-1:0] limit,
  output logic signed [tmacd_pkg::SUM_W-1:0] sum,
  output logic                          big
);
  import tmacd_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]          valid;
  logic signed [SAMPLE_W-1:0] oldest;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          abs_diff;
  logic                       big_next;

  // the sum moves by exactly new sample minus the sample it replaces
  always_comb begin
    diff     = {sample[SAMPLE_W-1], sample} - {oldest[SAMPLE_W-1], oldest};
    abs_diff = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    big_next = CMP_W'(abs_diff) >= CMP_W'(limit);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[ctl.slot] <= sample;
    end
  end

  // oldest holds the entry the next load replaces; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      oldest <= '0;
      sum    <= '0;
      big    <= 1'b0;
    end else if (ctl.load) begin
      valid[ctl.slot] <= 1'b1;
      sum             <= sum + SUM_W'(sample) - SUM_W'(oldest);
      big             <= big_next;
      if (ctl.slot_nxt == ctl.slot) begin
        oldest <= sample;
      end else if (valid[ctl.slot_nxt]) begin
        oldest <= mem[ctl.slot_nxt];
      end else begin
        oldest <= '0;
      end
    end
  end

endmodule

[rtl/tmacd_div.sv]
// ----------------------------------------------------------------------------
// tmacd_div
// window average: truncating division of a running sum by the window length
// ----------------------------------------------------------------------------
module tmacd_div (
  input  logic                               clk,
  input  tmacd_pkg::tmacd_ctl_t              ctl,
  input  logic signed [tmacd_pkg::SUM_W-1:0] sum,
  output logic signed [15:0]                 avg
);
  import tmacd_pkg::*;

  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic                neg;
  logic [SAMPLE_W-1:0] quo;

  assign mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign quo = prod[SHIFT_K +: SAMPLE_W];

  // divide the magnitude so the quotient truncates toward zero
  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      prod <= PROD_W'(mag) * PROD_W'(RECIP);
      neg  <= sum[SUM_W-1];
    end
    if (ctl.adv3) begin
      avg <= neg ? -quo : quo;
    end
  end

endmodule

[rtl/tmacd_merge.sv]
// ----------------------------------------------------------------------------
// tmacd_merge
// combines the per-axis change flags into one blink pulse with an armed flag
// ----------------------------------------------------------------------------
module tmacd_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  tmacd_pkg::tmacd_ctl_t           ctl,
  input  logic [tmacd_pkg::NUM_AXES-1:0]  bigs,
  output logic                            blink
);
  import tmacd_pkg::*;

  logic any_big;
  logic armed;
  logic blink_s2;

  assign any_big = |bigs;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (ctl.adv2) begin
      armed <= any_big;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      blink_s2 <= any_big & ~armed;
    end
    if (ctl.adv3) begin
      blink <= blink_s2;
    end
  end

endmodule

[rtl/triaxial_moving_average_change_detect.sv]
// ----------------------------------------------------------------------------
// triaxial_moving_average_change_detect
// three-axis moving average over a sample window with change detection
// ----------------------------------------------------------------------------
// One transaction in per cycle while the output is not stalled, one result
// out per transaction. Each axis runs in its own lane: the running sum takes
// one add and one subtract per cycle, which sets the rate of one item per
// clock. A result is registered in turn in the running sum, the reciprocal
// multiply and the output register. The window starts as zero samples
// through per-entry valid bits, so no clearing pass is needed after reset.
// The threshold may be written only while no transaction is in flight.
module triaxial_moving_average_change_detect (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // change_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // avg_x, avg_y, avg_z
  output logic        m_axis_tuser    // blink
);
  import tmacd_pkg::*;

  tmacd_ctl_t         ctl;
  logic               s1_v;
  logic               s2_v;
  logic               out_v;
  logic               out_en;
  logic               s2_free;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [LIMIT_W-1:0] limit;
  logic [NUM_AXES-1:0] bigs;
  logic signed [SUM_W-1:0] sums [NUM_AXES];
  logic signed [SAMPLE_W-1:0] avgs [NUM_AXES];

  // stall chain from the output register back to the input
  always_comb begin
    out_en        = ~out_v | m_axis_tready;
    s2_free       = ~s2_v | out_en;
    s_axis_tready = ~s1_v | s2_free;
    slot_nxt      = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    ctl.load      = s_axis_tvalid & s_axis_tready;
    ctl.adv2      = s1_v & s2_free;
    ctl.adv3      = s2_v & out_en;
    ctl.slot      = slot;
    ctl.slot_nxt  = slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
      slot  <= '0;
      limit <= LIMIT_RESET;
    end else begin
      if (ctl.load) begin
        s1_v <= 1'b1;
        slot <= slot_nxt;
      end else if (ctl.adv2) begin
        s1_v <= 1'b0;
      end
      if (ctl.adv2) begin
        s2_v <= 1'b1;
      end else if (ctl.adv3) begin
        s2_v <= 1'b0;
      end
      if (ctl.adv3) begin
        out_v <= 1'b1;
      end else if (m_axis_tready) begin
        out_v <= 1'b0;
      end
      // threshold kept pre-scaled so the test works on sums
      if (cfg_we) begin
        limit <= LIMIT_W'(cfg_wdata) * LIMIT_W'(WINDOW);
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tmacd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (s_axis_tdata[a*SAMPLE_W +: SAMPLE_W]),
      .limit  (limit),
      .sum    (sums[a]),
      .big    (bigs[a])
    );

    tmacd_div u_div (
      .clk (clk),
      .ctl (ctl),
      .sum (sums[a]),
      .avg (avgs[a])
    );

    assign m_axis_tdata[a*SAMPLE_W +: SAMPLE_W] = avgs[a];
  end

  tmacd_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .bigs  (bigs),
    .blink (m_axis_tuser)
  );

  assign m_axis_tvalid = out_v;

endmodule

[rtl/tmacd_checker.sv]
// ----------------------------------------------------------------------------
// tmacd_checker
// port-level checks of the triaxial moving average block, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmacd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic out_xfer;
  logic prev_blink;

  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // blink of the last delivered transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_blink <= 1'b0;
    end else if (out_xfer) begin
      prev_blink <= m_axis_tuser;
    end
  end

  `ASSERT_CLK_NR(a_rst_clears_out, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  `ASSERT_CLK(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

  `ASSERT_CLK(a_no_double_blink, clk, rst, out_xfer && prev_blink |-> !m_axis_tuser,
    "blink on two results in a row")

  `ASSERT_CLK(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready,
    "input stalled with an empty output register")

endmodule

bind triaxial_moving_average_change_detect tmacd_checker u_tmacd_checker (.*);
